// ===== rtl/avgp_pkg.sv =====
// Shared constants and register indexes for the average pooling block.
// Used by the line-store RAM and the top level; no dependencies.
package avgp_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_POOL   = 8;
	localparam int PIXEL_BITS = 16;
	localparam int STEP_MAX   = 8;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
	localparam int ADDR_W = ROW_W + COL_W;

	typedef enum logic [1:0] {
		REG_IMAGE_SIZE  = 2'd0,
		REG_WINDOW_SIZE = 2'd1,
		REG_STEP        = 2'd2
	} reg_idx_t;

endpackage

// ===== rtl/avg_pool_2d_core.sv =====
// Streaming 2-D average pooling over a square raster image.
// Depends on avgp_pkg and avgp_line_ram.
//
// Pixels arrive one word at a time in raster order and are written into a
// line store of the most recent rows. A pixel that closes a window stalls
// the pixel input until its result word is loaded: the window is read back
// one entry a cycle through the single read port of the line store, then
// the mean is formed by a bit-serial divider of 24 steps
// (round to nearest, halves away from zero), then the result word is loaded
// into the output register. A waiting result word stalls the pixel input only
// once the next window's mean is ready to load. Registers: image_size at 0x0,
// window_size at 0x4, step at 0x8; any register write restarts the image at
// row 0, column 0.
module avg_pool_2d_core import avgp_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [3:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  logic signed [PIXEL_BITS-1:0] pixel,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [PIXEL_BITS-1:0] mean,
	output logic [7:0]                   out_row,
	output logic [7:0]                   out_col,
	output logic                         last_of_image
);

	localparam int N_W     = $clog2(MAX_WIDTH + 1);
	localparam int P_W     = $clog2(MAX_POOL + 1);
	localparam int S_W     = $clog2(STEP_MAX + 1);
	localparam int PH_W    = $clog2(STEP_MAX);
	localparam int AB_W    = ROW_W;
	localparam int SUM_W   = PIXEL_BITS + 2 * $clog2(MAX_POOL) + 1;
	localparam int D_W     = $clog2(MAX_POOL * MAX_POOL + 1);
	localparam int DEN_W   = D_W + 1;
	localparam int NUM_W   = SUM_W + 1;
	localparam int CNT_W   = $clog2(NUM_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	// configuration
	logic [8:0] image_size_q;
	logic [3:0] window_size_q;
	logic [3:0] step_q;
	logic       cfg_wr;
	reg_idx_t   cfg_idx;

	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q  <= 9'd16;
			window_size_q <= 4'd2;
			step_q        <= 4'd2;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_IMAGE_SIZE:  image_size_q  <= pwdata[8:0];
				REG_WINDOW_SIZE: window_size_q <= pwdata[3:0];
				REG_STEP:        step_q        <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_IMAGE_SIZE:  prdata = {23'd0, image_size_q};
			REG_WINDOW_SIZE: prdata = {28'd0, window_size_q};
			REG_STEP:        prdata = {28'd0, step_q};
			default:         prdata = 32'd0;
		endcase
	end

	logic [N_W-1:0] n_w;
	logic [P_W-1:0] p_w;
	logic [S_W-1:0] s_w;

	always_comb begin
		if (image_size_q == 9'd0) begin
			n_w = N_W'(1);
		end else if (N_W'(image_size_q) > N_W'(MAX_WIDTH)) begin
			n_w = N_W'(MAX_WIDTH);
		end else begin
			n_w = N_W'(image_size_q);
		end
		if (window_size_q == 4'd0) begin
			p_w = P_W'(1);
		end else if (P_W'(window_size_q) > P_W'(MAX_POOL)) begin
			p_w = P_W'(MAX_POOL);
		end else begin
			p_w = P_W'(window_size_q);
		end
		if (step_q == 4'd0) begin
			s_w = S_W'(1);
		end else if (S_W'(step_q) > S_W'(STEP_MAX)) begin
			s_w = S_W'(STEP_MAX);
		end else begin
			s_w = S_W'(step_q);
		end
	end

	// position tracking
	state_t          state_q;
	logic            accept;
	logic [7:0]      row_q, col_q;
	logic [PH_W-1:0] rph_q, cph_q;
	logic [7:0]      oi_q, oj_q;
	logic [N_W-1:0]  r1, c1, r_end, c_end;
	logic            row_ok, col_ok, row_hit, col_hit, hit, col_wrap, row_wrap;
	logic            rph_wrap, cph_wrap;

	assign pixel_stall = (state_q != ST_IDLE);
	assign accept      = pixel_valid & ~pixel_stall;

	assign r1       = N_W'(row_q) + N_W'(1);
	assign c1       = N_W'(col_q) + N_W'(1);
	assign r_end    = N_W'(row_q) + N_W'(s_w);
	assign c_end    = N_W'(col_q) + N_W'(s_w);
	assign row_ok   = r1 >= N_W'(p_w);
	assign col_ok   = c1 >= N_W'(p_w);
	assign row_hit  = row_ok && (rph_q == '0);
	assign col_hit  = col_ok && (cph_q == '0);
	assign hit      = row_hit && col_hit && (n_w >= N_W'(p_w));
	assign col_wrap = (c1 == n_w);
	assign row_wrap = (r1 == n_w);
	assign rph_wrap = (S_W'(rph_q) + S_W'(1)) == s_w;
	assign cph_wrap = (S_W'(cph_q) + S_W'(1)) == s_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			rph_q <= '0;
			cph_q <= '0;
			oi_q  <= '0;
			oj_q  <= '0;
		end else if (cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
			rph_q <= '0;
			cph_q <= '0;
			oi_q  <= '0;
			oj_q  <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				cph_q <= '0;
				oj_q  <= '0;
				if (row_wrap) begin
					row_q <= '0;
					rph_q <= '0;
					oi_q  <= '0;
				end else begin
					row_q <= r1[7:0];
					if (row_ok) begin
						if (rph_wrap) begin
							rph_q <= '0;
							oi_q  <= oi_q + 8'd1;
						end else begin
							rph_q <= rph_q + PH_W'(1);
						end
					end
				end
			end else begin
				col_q <= c1[7:0];
				if (col_ok) begin
					if (cph_wrap) begin
						cph_q <= '0;
						oj_q  <= oj_q + 8'd1;
					end else begin
						cph_q <= cph_q + PH_W'(1);
					end
				end
			end
		end
	end

	// line store
	logic [ROW_W-1:0]      base_row_q;
	logic [COL_W-1:0]      base_col_q;
	logic [AB_W-1:0]       a_q, b_q;
	logic                  issue_q, rd_vld_s1, rd_last_s1;
	logic                  last_issue;
	logic [ADDR_W-1:0]     raddr;
	logic [PIXEL_BITS-1:0] rdata;
	logic [ROW_W-1:0]      rd_row;
	logic [COL_W-1:0]      rd_col;

	assign rd_row     = base_row_q + ROW_W'(a_q);
	assign rd_col     = base_col_q + COL_W'(b_q);
	assign raddr      = {rd_row, rd_col};
	assign last_issue = (P_W'(a_q) + P_W'(1) == p_w) && (P_W'(b_q) + P_W'(1) == p_w);

	avgp_line_ram u_line_ram (
		.clk   (clk),
		.we    (accept),
		.waddr ({row_q[ROW_W-1:0], col_q[COL_W-1:0]}),
		.wdata (pixel),
		.re    (issue_q && (state_q == ST_SUM)),
		.raddr (raddr),
		.rdata (rdata)
	);

	// accumulate and divide
	logic signed [SUM_W-1:0] acc_q, sum_fin;
	logic [SUM_W-1:0]        mag;
	logic [D_W-1:0]          d_w;
	logic [NUM_W-1:0]        num_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DEN_W:0]          trial;
	logic                    ge;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [7:0]              oi_res_q, oj_res_q;
	logic                    last_res_q;
	logic [PIXEL_BITS-1:0]   q_mag;

	assign sum_fin = acc_q + SUM_W'(signed'(rdata));
	assign mag     = sum_fin[SUM_W-1] ? SUM_W'(-sum_fin) : SUM_W'(sum_fin);
	assign d_w     = D_W'(p_w) * D_W'(p_w);
	assign trial   = {rem_q, num_q[NUM_W-1]};
	assign ge      = trial >= {1'b0, den_q};
	assign q_mag   = num_q[PIXEL_BITS-1:0];

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			base_row_q <= ROW_W'(r1 - N_W'(p_w));
			base_col_q <= COL_W'(c1 - N_W'(p_w));
			oi_res_q   <= oi_q;
			oj_res_q   <= oj_q;
			last_res_q <= (c_end >= n_w) && (r_end >= n_w);
			acc_q      <= '0;
		end
		if (state_q == ST_SUM && rd_vld_s1) begin
			acc_q <= sum_fin;
			if (rd_last_s1) begin
				neg_q <= sum_fin[SUM_W-1];
				num_q <= {mag, 1'b0} + NUM_W'(d_w);
				den_q <= {d_w, 1'b0};
				rem_q <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	// control and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			a_q           <= '0;
			b_q           <= '0;
			issue_q       <= 1'b0;
			rd_vld_s1     <= 1'b0;
			rd_last_s1    <= 1'b0;
			cnt_q         <= '0;
			result_valid  <= 1'b0;
			mean          <= '0;
			out_row       <= '0;
			out_col       <= '0;
			last_of_image <= 1'b0;
		end else begin
			if (result_valid && !result_stall && state_q != ST_OUT) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && hit) begin
						a_q        <= '0;
						b_q        <= '0;
						issue_q    <= 1'b1;
						rd_vld_s1  <= 1'b0;
						rd_last_s1 <= 1'b0;
						state_q    <= ST_SUM;
					end
				end
				ST_SUM: begin
					rd_vld_s1  <= issue_q;
					rd_last_s1 <= issue_q && last_issue;
					if (issue_q) begin
						if (last_issue) begin
							issue_q <= 1'b0;
						end else if (P_W'(b_q) + P_W'(1) == p_w) begin
							b_q <= '0;
							a_q <= a_q + AB_W'(1);
						end else begin
							b_q <= b_q + AB_W'(1);
						end
					end
					if (rd_vld_s1 && rd_last_s1) begin
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_OUT: begin
					if (!result_valid || !result_stall) begin
						result_valid  <= 1'b1;
						mean          <= neg_q ? -signed'(q_mag) : signed'(q_mag);
						out_row       <= oi_res_q;
						out_col       <= oj_res_q;
						last_of_image <= last_res_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/avgp_line_ram.sv =====
// Line store: MAX_POOL rows of MAX_WIDTH pixels, one write and one read port,
// read data registered. Depends on avgp_pkg.
module avgp_line_ram import avgp_pkg::*; (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  logic [PIXEL_BITS-1:0] wdata,
	input  logic                  re,
	input  logic [ADDR_W-1:0]     raddr,
	output logic [PIXEL_BITS-1:0] rdata
);

	logic [PIXEL_BITS-1:0] mem [MAX_POOL*MAX_WIDTH];
	logic [PIXEL_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
